/* hdl/tpz_pkg.sv */
// ----------------------------------------------------------------------------
// tpz_pkg
// shared types, constants and tables of the torus point renderer
// ----------------------------------------------------------------------------
package tpz_pkg;

  // frame defaults and fixed field widths
  localparam int DEF_FRAME_COLS = 64;
  localparam int DEF_FRAME_ROWS = 32;
  localparam int ANGLE_STEPS    = 512;
  localparam int ANG_W          = 9;
  localparam int COL_W          = 6;
  localparam int ROW_W          = 5;
  localparam int GLYPH_W        = 8;
  localparam int DEPTH_W        = 16;
  localparam int FUNC_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_W          = 9;

  // datapath widths
  localparam int T_W   = 16;          // q1.14 trig value
  localparam int V_W   = 24;          // geometry values in q14
  localparam int MB_W  = 18;          // second multiplier operand
  localparam int P_W   = V_W + MB_W;  // product
  localparam int VV_W  = 32;          // position times view distance
  localparam int NUM_W = 40;          // projection numerator
  localparam int DEN_W = 34;          // projection denominator

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLOT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN  = 3'd4;

  localparam logic [3:0]       RST_MAJOR = 4'd2;
  localparam logic [3:0]       RST_MINOR = 4'd1;
  localparam logic [7:0]       RST_VIEW  = 8'd80;
  localparam logic [ANG_W-1:0] RST_ANGLE = '0;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;
  localparam logic [3:0]         LI_MAX      = 4'd11;
  localparam logic [63:0]        PI_Q30      = 64'd3373259426;

  typedef enum logic [1:0] {OP_CLEAR, OP_PLOT, OP_READ, OP_NOP} op_t;

  typedef struct packed {
    logic [3:0]       major_radius;
    logic [3:0]       minor_radius;
    logic [7:0]       view_distance;
    logic [ANG_W-1:0] tilt_angle;
    logic [ANG_W-1:0] spin_angle;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [ANG_W-1:0] theta;
    logic [ANG_W-1:0] phi;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             in_frame;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [GLYPH_W-1:0] glyph;
    logic               drawn;
    logic               off_screen;
  } res_t;

  typedef enum logic [5:0] {
    S_SWEEP, S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_CY, S_TX, S_TZ,
    S_TY2A, S_TY2B, S_TZ2A, S_TZ2B, S_TX3A, S_TX3B, S_TY3A, S_TY3B,
    S_NX, S_NZ, S_NY2A, S_NY2B, S_NZ2A, S_NZ2B, S_NY3A, S_NY3B,
    S_Z, S_DEN, S_VX, S_VY, S_NUMY, S_DXGO, S_DX, S_DYGO, S_DY, S_CHK,
    S_DIGO, S_DI, S_RD, S_CMP, S_RRD, S_RDONE, S_OUT
  } eng_state_t;

  // sine or cosine of 2*pi*k/ANGLE_STEPS in q1.14, taylor series in q30
  function automatic logic signed [T_W-1:0] trig_q14(int unsigned k, bit cosine);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] r;
    bit          neg;
    x   = (64'(k) * 64'd2 * PI_Q30) / 64'(ANGLE_STEPS);
    neg = 1'b0;
    if (cosine) begin
      x = x + PI_Q30 / 2;
      if (x >= 2 * PI_Q30) x = x - 2 * PI_Q30;
    end
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > PI_Q30 / 2) x = PI_Q30 - x;
    s = x;
    t = x;
    for (int n = 1; n <= 5; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) s = s - t;
      else s = s + t;
    end
    r = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return neg ? -T_W'(r) : T_W'(r);
  endfunction

  typedef logic [2*T_W-1:0] trig_tab_t [ANGLE_STEPS];

  // entry k holds {sine, cosine}
  function automatic trig_tab_t make_trig_tab();
    trig_tab_t tab;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      tab[k] = {trig_q14(k, 1'b0), trig_q14(k, 1'b1)};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = make_trig_tab();

  function automatic logic [GLYPH_W-1:0] ramp_glyph(logic [3:0] i);
    logic [GLYPH_W-1:0] g;
    case (i)
      4'd0:    g = 8'h2E;  // .
      4'd1:    g = 8'h2C;  // ,
      4'd2:    g = 8'h2D;  // -
      4'd3:    g = 8'h7E;  // ~
      4'd4:    g = 8'h3A;  // :
      4'd5:    g = 8'h3B;  // ;
      4'd6:    g = 8'h3D;  // =
      4'd7:    g = 8'h21;  // !
      4'd8:    g = 8'h2A;  // *
      4'd9:    g = 8'h23;  // #
      4'd10:   g = 8'h24;  // $
      default: g = 8'h40;  // @
    endcase
    return g;
  endfunction

endpackage

/* hdl/torus_point_zbuffer_renderer.sv */
// ----------------------------------------------------------------------------
// torus_point_zbuffer_renderer
// torus surface sample renderer with a glyph frame and a depth buffer
// ----------------------------------------------------------------------------
// plot: multiply steps on the shared multiplier, then three passes of the
//   radix-2 divider (column, row, inverse depth)
// read: one frame memory read; clear: one frame memory cell a cycle
// one item in the engine at a time; two-entry queues on input and result side
// reset: synchronous, active low; a clearing pass of the frame memory
//   follows reset, with in_full held high until it ends
module torus_point_zbuffer_renderer
  import tpz_pkg::*;
#(
  parameter int FRAME_COLS = DEF_FRAME_COLS,
  parameter int FRAME_ROWS = DEF_FRAME_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // item channel
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [ANG_W-1:0]     in_theta_index,
  input  logic [ANG_W-1:0]     in_phi_index,
  input  logic [COL_W-1:0]     in_read_col,
  input  logic [ROW_W-1:0]     in_read_row,
  // result channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [COL_W-1:0]     out_cell_col,
  output logic [ROW_W-1:0]     out_cell_row,
  output logic [GLYPH_W-1:0]   out_glyph,
  output logic                 out_drawn,
  output logic                 out_off_screen
);

  // configuration registers
  cfg_t cfg_r, cfg_nxt;

  // front to engine
  item_t item;
  logic  item_valid, item_ready;

  // engine to result queue
  res_t  res;
  logic  res_valid, res_ready;
  logic  init_busy;

  // result queue
  res_t       oq_r [2];
  logic       oq_wr_r, oq_wr_nxt;
  logic       oq_rd_r, oq_rd_nxt;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_push, oq_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAJOR: cfg_nxt.major_radius  = cfg_data[3:0];
        CFG_MINOR: cfg_nxt.minor_radius  = cfg_data[3:0];
        CFG_VIEW:  cfg_nxt.view_distance = cfg_data[7:0];
        CFG_TILT:  cfg_nxt.tilt_angle    = cfg_data[ANG_W-1:0];
        CFG_SPIN:  cfg_nxt.spin_angle    = cfg_data[ANG_W-1:0];
        default:   cfg_nxt = cfg_r;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.major_radius  <= RST_MAJOR;
      cfg_r.minor_radius  <= RST_MINOR;
      cfg_r.view_distance <= RST_VIEW;
      cfg_r.tilt_angle    <= RST_ANGLE;
      cfg_r.spin_angle    <= RST_ANGLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accepts and decodes items, held full during the reset clearing pass
  tpz_front #(
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (init_busy),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_theta_index (in_theta_index),
    .in_phi_index   (in_phi_index),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .item           (item),
    .item_valid     (item_valid),
    .item_ready     (item_ready)
  );

  // back: geometry, projection, depth test and frame memory
  tpz_engine #(
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .init_busy  (init_busy)
  );

  // two-entry result queue, so the engine moves on while a result waits
  assign res_ready = (oq_cnt_r != 2'd2);
  assign oq_push   = res_valid && res_ready;
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop && !out_empty;

  always_comb begin
    oq_wr_nxt  = oq_wr_r ^ oq_push;
    oq_rd_nxt  = oq_rd_r ^ oq_pop;
    oq_cnt_nxt = oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wr_r] <= res;
  end

  // oldest result on the ports while the queue holds one
  assign out_cell_col   = oq_r[oq_rd_r].cell_col;
  assign out_cell_row   = oq_r[oq_rd_r].cell_row;
  assign out_glyph      = oq_r[oq_rd_r].glyph;
  assign out_drawn      = oq_r[oq_rd_r].drawn;
  assign out_off_screen = oq_r[oq_rd_r].off_screen;

endmodule

/* hdl/tpz_front.sv */
// ----------------------------------------------------------------------------
// tpz_front
// input queue: accepts items, decodes the function and checks read bounds
// ----------------------------------------------------------------------------
module tpz_front
  import tpz_pkg::*;
#(
  parameter int FRAME_COLS = DEF_FRAME_COLS,
  parameter int FRAME_ROWS = DEF_FRAME_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hold,
  input  logic              in_push,
  output logic              in_full,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ANG_W-1:0]  in_theta_index,
  input  logic [ANG_W-1:0]  in_phi_index,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [ROW_W-1:0]  in_read_row,
  output item_t             item,
  output logic              item_valid,
  input  logic              item_ready
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;
  item_t      dec;

  always_comb begin
    dec.theta    = in_theta_index;
    dec.phi      = in_phi_index;
    dec.col      = in_read_col;
    dec.row      = in_read_row;
    dec.in_frame = (int'(in_read_col) < FRAME_COLS) && (int'(in_read_row) < FRAME_ROWS);
    case (in_func)
      FUNC_CLEAR: dec.op = OP_CLEAR;
      FUNC_PLOT:  dec.op = OP_PLOT;
      FUNC_READ:  dec.op = OP_READ;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_full    = (cnt_r == 2'd2) || hold;
  assign push_ok    = in_push && !in_full;
  assign item_valid = (cnt_r != 2'd0);
  assign pop_ok     = item_valid && item_ready;
  assign item       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) slot_r[wr_ptr_r] <= dec;
  end

endmodule

/* hdl/tpz_div.sv */
// ----------------------------------------------------------------------------
// tpz_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tpz_div
  import tpz_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

/* hdl/tpz_engine.sv */
// ----------------------------------------------------------------------------
// tpz_engine
// back end: sequencer over one multiplier, divider, trig rom and frame memory
// ----------------------------------------------------------------------------
module tpz_engine
  import tpz_pkg::*;
#(
  parameter int FRAME_COLS = DEF_FRAME_COLS,
  parameter int FRAME_ROWS = DEF_FRAME_ROWS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  item_valid,
  output logic  item_ready,
  output res_t  res,
  output logic  res_valid,
  input  logic  res_ready,
  output logic  init_busy
);

  localparam int CELLS  = FRAME_COLS * FRAME_ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int MEM_W  = GLYPH_W + DEPTH_W;

  eng_state_t state_r, state_nxt;

  logic signed [T_W-1:0] cth_r, sth_r, cph_r, sph_r, ca_r, sa_r, cb_r, sb_r;
  logic signed [T_W-1:0] cth_nxt, sth_nxt, cph_nxt, sph_nxt;
  logic signed [T_W-1:0] ca_nxt, sa_nxt, cb_nxt, sb_nxt;
  logic signed [V_W-1:0] cx_r, cy_r, tx_r, tz_r, ty2_r, tz2_r, tx3_r, ty3_r;
  logic signed [V_W-1:0] cx_nxt, cy_nxt, tx_nxt, tz_nxt, ty2_nxt, tz2_nxt, tx3_nxt, ty3_nxt;
  logic signed [V_W-1:0] nx_r, nz_r, ny2_r, nz2_r, acc_r, lum_r, z_r;
  logic signed [V_W-1:0] nx_nxt, nz_nxt, ny2_nxt, nz2_nxt, acc_nxt, lum_nxt, z_nxt;
  logic signed [VV_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic signed [NUM_W-1:0] numx_r, numx_nxt, numy_r, numy_nxt;
  logic [NUM_W-1:0]        qx_r, qx_nxt, qy_r, qy_nxt;
  logic                    negx_r, negx_nxt, negy_r, negy_nxt;
  logic [DEPTH_W-1:0]      inv_r, inv_nxt;
  logic [CELL_W-1:0]       cell_r, cell_nxt, cnt_r, cnt_nxt;
  logic [ANG_W-1:0]        theta_r, theta_nxt, phi_r, phi_nxt;
  logic                    clr_pend_r, clr_pend_nxt;
  res_t                    res_r, res_nxt;

  // trig rom and frame memory
  logic [ANG_W-1:0]   rom_addr;
  logic [2*T_W-1:0]   rom_q_r;
  logic [MEM_W-1:0]   frame_mem [CELLS];
  logic [MEM_W-1:0]   mem_q_r;
  logic [CELL_W-1:0]  mem_addr;
  logic [MEM_W-1:0]   mem_wdata;
  logic               mem_we;

  // shared multiplier
  logic signed [V_W-1:0]  ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  prod;
  logic signed [V_W-1:0]  mqv;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  logic [4:0]            rsum;
  logic                  offx, offy;
  logic signed [V_W-1:0] lsh;
  logic [3:0]            li;

  tpz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign rsum = (cfg.major_radius + cfg.minor_radius == 5'd0) ? 5'd1
              : 5'(cfg.major_radius) + 5'(cfg.minor_radius);
  assign prod = ma * mb;
  assign mqv  = V_W'(prod >>> 14);
  assign lsh  = lum_r >>> 11;
  assign li   = (lum_r < 0) ? 4'd0 : ((lsh > V_W'(LI_MAX)) ? LI_MAX : 4'(lsh));

  assign offx = (negx_r && qx_r != '0) || (qx_r >= NUM_W'(FRAME_COLS));
  assign offy = (negy_r && qy_r != '0) || (qy_r >= NUM_W'(FRAME_ROWS));

  assign res        = res_r;
  assign res_valid  = (state_r == S_OUT);
  assign item_ready = (state_r == S_IDLE);
  assign init_busy  = (state_r == S_SWEEP) && !clr_pend_r;

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_T4:   begin ma = V_W'(cfg.minor_radius); mb = MB_W'(cph_r); end
      S_CY:   begin ma = V_W'(cfg.minor_radius); mb = MB_W'(sph_r); end
      S_TX:   begin ma = cx_r;  mb = MB_W'(cth_r); end
      S_TZ:   begin ma = cx_r;  mb = MB_W'(sth_r); end
      S_TY2A: begin ma = cy_r;  mb = MB_W'(ca_r);  end
      S_TY2B: begin ma = tz_r;  mb = MB_W'(sa_r);  end
      S_TZ2A: begin ma = tz_r;  mb = MB_W'(ca_r);  end
      S_TZ2B: begin ma = cy_r;  mb = MB_W'(sa_r);  end
      S_TX3A: begin ma = tx_r;  mb = MB_W'(cb_r);  end
      S_TX3B: begin ma = ty2_r; mb = MB_W'(sb_r);  end
      S_TY3A: begin ma = ty2_r; mb = MB_W'(cb_r);  end
      S_TY3B: begin ma = tx_r;  mb = MB_W'(sb_r);  end
      S_NX:   begin ma = V_W'(cph_r); mb = MB_W'(cth_r); end
      S_NZ:   begin ma = V_W'(sth_r); mb = MB_W'(cph_r); end
      S_NY2A: begin ma = V_W'(sph_r); mb = MB_W'(ca_r);  end
      S_NY2B: begin ma = nz_r;  mb = MB_W'(sa_r);  end
      S_NZ2A: begin ma = nz_r;  mb = MB_W'(ca_r);  end
      S_NZ2B: begin ma = V_W'(sph_r); mb = MB_W'(sa_r); end
      S_NY3A: begin ma = ny2_r; mb = MB_W'(cb_r);  end
      S_NY3B: begin ma = nx_r;  mb = MB_W'(sb_r);  end
      S_DEN:  begin ma = z_r;   mb = MB_W'(rsum);  end
      S_VX:   begin ma = tx3_r; mb = MB_W'(cfg.view_distance); end
      S_VY:   begin ma = ty3_r; mb = MB_W'(cfg.view_distance); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cth_nxt = cth_r; sth_nxt = sth_r; cph_nxt = cph_r; sph_nxt = sph_r;
    ca_nxt  = ca_r;  sa_nxt  = sa_r;  cb_nxt  = cb_r;  sb_nxt  = sb_r;
    cx_nxt  = cx_r;  cy_nxt  = cy_r;  tx_nxt  = tx_r;  tz_nxt  = tz_r;
    ty2_nxt = ty2_r; tz2_nxt = tz2_r; tx3_nxt = tx3_r; ty3_nxt = ty3_r;
    nx_nxt  = nx_r;  nz_nxt  = nz_r;  ny2_nxt = ny2_r; nz2_nxt = nz2_r;
    acc_nxt = acc_r; lum_nxt = lum_r; z_nxt   = z_r;
    vx_nxt  = vx_r;  vy_nxt  = vy_r;  den_nxt = den_r;
    numx_nxt = numx_r; numy_nxt = numy_r;
    qx_nxt  = qx_r;  qy_nxt  = qy_r;  negx_nxt = negx_r; negy_nxt = negy_r;
    inv_nxt = inv_r; cell_nxt = cell_r; cnt_nxt = cnt_r;
    theta_nxt = theta_r; phi_nxt = phi_r;
    clr_pend_nxt = clr_pend_r;
    res_nxt   = res_r;
    rom_addr  = theta_r;
    mem_addr  = cell_r;
    mem_we    = 1'b0;
    mem_wdata = {BLANK_GLYPH, DEPTH_W'(0)};
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;

    case (state_r)
      S_SWEEP: begin
        mem_addr = cnt_r;
        mem_we   = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CELL_W'(CELLS - 1)) begin
          if (clr_pend_r) begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
          clr_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          res_nxt = '0;
          case (item.op)
            OP_CLEAR: begin
              cnt_nxt      = '0;
              clr_pend_nxt = 1'b1;
              state_nxt    = S_SWEEP;
            end
            OP_PLOT: begin
              theta_nxt = item.theta;
              phi_nxt   = item.phi;
              state_nxt = S_T0;
            end
            OP_READ: begin
              res_nxt.cell_col = item.col;
              res_nxt.cell_row = item.row;
              cell_nxt = CELL_W'(int'(item.row) * FRAME_COLS + int'(item.col));
              if (item.in_frame) begin
                state_nxt = S_RRD;
              end else begin
                res_nxt.off_screen = 1'b1;
                state_nxt = S_OUT;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RRD:   state_nxt = S_RDONE;
      S_RDONE: begin
        res_nxt.glyph = mem_q_r[MEM_W-1:DEPTH_W];
        state_nxt     = S_OUT;
      end
      // trig fetch, one rom read per angle
      S_T0: begin rom_addr = theta_r; state_nxt = S_T1; end
      S_T1: begin
        rom_addr = phi_r;
        {sth_nxt, cth_nxt} = rom_q_r;
        state_nxt = S_T2;
      end
      S_T2: begin
        rom_addr = cfg.tilt_angle;
        {sph_nxt, cph_nxt} = rom_q_r;
        state_nxt = S_T3;
      end
      S_T3: begin
        rom_addr = cfg.spin_angle;
        {sa_nxt, ca_nxt} = rom_q_r;
        state_nxt = S_T4;
      end
      S_T4: begin
        {sb_nxt, cb_nxt} = rom_q_r;
        cx_nxt    = (V_W'(cfg.major_radius) <<< 14) + V_W'(prod);
        state_nxt = S_CY;
      end
      S_CY:   begin cy_nxt = V_W'(prod);  state_nxt = S_TX;   end
      // surface point rotation
      S_TX:   begin tx_nxt = mqv;         state_nxt = S_TZ;   end
      S_TZ:   begin tz_nxt = -mqv;        state_nxt = S_TY2A; end
      S_TY2A: begin acc_nxt = mqv;        state_nxt = S_TY2B; end
      S_TY2B: begin ty2_nxt = acc_r + mqv; state_nxt = S_TZ2A; end
      S_TZ2A: begin acc_nxt = mqv;        state_nxt = S_TZ2B; end
      S_TZ2B: begin tz2_nxt = acc_r - mqv; state_nxt = S_TX3A; end
      S_TX3A: begin acc_nxt = mqv;        state_nxt = S_TX3B; end
      S_TX3B: begin tx3_nxt = acc_r + mqv; state_nxt = S_TY3A; end
      S_TY3A: begin acc_nxt = mqv;        state_nxt = S_TY3B; end
      S_TY3B: begin ty3_nxt = acc_r - mqv; state_nxt = S_NX;   end
      // normal rotation and luminance
      S_NX:   begin nx_nxt = mqv;         state_nxt = S_NZ;   end
      S_NZ:   begin nz_nxt = -mqv;        state_nxt = S_NY2A; end
      S_NY2A: begin acc_nxt = mqv;        state_nxt = S_NY2B; end
      S_NY2B: begin ny2_nxt = acc_r + mqv; state_nxt = S_NZ2A; end
      S_NZ2A: begin acc_nxt = mqv;        state_nxt = S_NZ2B; end
      S_NZ2B: begin nz2_nxt = acc_r - mqv; state_nxt = S_NY3A; end
      S_NY3A: begin acc_nxt = mqv;        state_nxt = S_NY3B; end
      S_NY3B: begin lum_nxt = acc_r - mqv - nz2_r; state_nxt = S_Z; end
      // projection
      S_Z: begin
        z_nxt     = (V_W'(cfg.view_distance) <<< 10) + tz2_r;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        if (z_r <= 0) begin
          res_nxt.off_screen = 1'b1;
          state_nxt = S_OUT;
        end else begin
          den_nxt   = DEN_W'(prod) << 7;
          state_nxt = S_VX;
        end
      end
      S_VX: begin vx_nxt = VV_W'(prod); state_nxt = S_VY; end
      S_VY: begin
        vy_nxt   = VV_W'(prod);
        numx_nxt = NUM_W'(den_r) * NUM_W'(FRAME_COLS)
                 + NUM_W'(vx_r) * NUM_W'(6 * FRAME_COLS);
        state_nxt = S_NUMY;
      end
      S_NUMY: begin
        numy_nxt = NUM_W'(den_r) * NUM_W'(FRAME_ROWS)
                 - NUM_W'(vy_r) * NUM_W'(6 * FRAME_ROWS);
        state_nxt = S_DXGO;
      end
      S_DXGO: begin
        div_start = 1'b1;
        div_num   = numx_r[NUM_W-1] ? NUM_W'(-numx_r) : NUM_W'(numx_r);
        div_den   = den_r << 1;
        negx_nxt  = numx_r[NUM_W-1];
        state_nxt = S_DX;
      end
      S_DX: if (div_done) begin qx_nxt = div_quo; state_nxt = S_DYGO; end
      S_DYGO: begin
        div_start = 1'b1;
        div_num   = numy_r[NUM_W-1] ? NUM_W'(-numy_r) : NUM_W'(numy_r);
        div_den   = den_r << 1;
        negy_nxt  = numy_r[NUM_W-1];
        state_nxt = S_DY;
      end
      S_DY: if (div_done) begin qy_nxt = div_quo; state_nxt = S_CHK; end
      S_CHK: begin
        if (offx || offy) begin
          res_nxt.off_screen = 1'b1;
          state_nxt = S_OUT;
        end else begin
          res_nxt.cell_col = qx_r[COL_W-1:0];
          res_nxt.cell_row = qy_r[ROW_W-1:0];
          cell_nxt = CELL_W'(int'(qy_r[ROW_W-1:0]) * FRAME_COLS + int'(qx_r[COL_W-1:0]));
          state_nxt = S_DIGO;
        end
      end
      S_DIGO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(1) << 28;
        div_den   = DEN_W'(z_r);
        state_nxt = S_DI;
      end
      S_DI: if (div_done) begin
        inv_nxt   = (div_quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : DEPTH_W'(div_quo);
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        // depth test against the stored inverse depth
        if (inv_r > mem_q_r[DEPTH_W-1:0]) begin
          mem_we        = 1'b1;
          mem_wdata     = {ramp_glyph(li), inv_r};
          res_nxt.glyph = ramp_glyph(li);
          res_nxt.drawn = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      cnt_r      <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cth_r <= cth_nxt; sth_r <= sth_nxt; cph_r <= cph_nxt; sph_r <= sph_nxt;
    ca_r  <= ca_nxt;  sa_r  <= sa_nxt;  cb_r  <= cb_nxt;  sb_r  <= sb_nxt;
    cx_r  <= cx_nxt;  cy_r  <= cy_nxt;  tx_r  <= tx_nxt;  tz_r  <= tz_nxt;
    ty2_r <= ty2_nxt; tz2_r <= tz2_nxt; tx3_r <= tx3_nxt; ty3_r <= ty3_nxt;
    nx_r  <= nx_nxt;  nz_r  <= nz_nxt;  ny2_r <= ny2_nxt; nz2_r <= nz2_nxt;
    acc_r <= acc_nxt; lum_r <= lum_nxt; z_r   <= z_nxt;
    vx_r  <= vx_nxt;  vy_r  <= vy_nxt;  den_r <= den_nxt;
    numx_r <= numx_nxt; numy_r <= numy_nxt;
    qx_r  <= qx_nxt;  qy_r  <= qy_nxt;  negx_r <= negx_nxt; negy_r <= negy_nxt;
    inv_r <= inv_nxt; cell_r <= cell_nxt;
    theta_r <= theta_nxt; phi_r <= phi_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    rom_q_r <= TRIG_TAB[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_addr] <= mem_wdata;
    mem_q_r <= frame_mem[mem_addr];
  end

endmodule

/* tb/tpz_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpz_checker
// predicts each renderer result from the accepted items and register writes,
// keeps its own glyph and depth frame, and compares every popped result
// ----------------------------------------------------------------------------
module tpz_checker
  import tpz_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [ANG_W-1:0]     in_theta_index,
  input  logic [ANG_W-1:0]     in_phi_index,
  input  logic [COL_W-1:0]     in_read_col,
  input  logic [ROW_W-1:0]     in_read_row,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [COL_W-1:0]     out_cell_col,
  input  logic [ROW_W-1:0]     out_cell_row,
  input  logic [GLYPH_W-1:0]   out_glyph,
  input  logic                 out_drawn,
  input  logic                 out_off_screen,
  output int                   errors,
  output int                   waiting,
  output int                   drawn_cnt,
  output int                   dropped_cnt
);

  localparam int COLS  = 64;
  localparam int ROWS  = 32;
  localparam int STEPS = 512;

  logic [GLYPH_W-1:0] glyph_mem [COLS*ROWS];
  logic [DEPTH_W-1:0] depth_mem [COLS*ROWS];
  logic [3:0]         major_r, minor_r;
  logic [7:0]         view_d;
  logic [ANG_W-1:0]   tilt, spin;
  res_t               pending_q [$];
  string              shade = ".,-~:;=!*#$@";

  // q1.14 sine or cosine of 2*pi*k/STEPS, taylor series in q30
  function automatic longint wave_q14(int unsigned k, bit cos_sel);
    longint unsigned pi_q, x, s, t, r;
    bit neg;
    pi_q = 64'd3373259426;
    x    = (64'(k % STEPS) * 64'd2 * pi_q) / 64'(STEPS);
    neg  = 1'b0;
    if (cos_sel) begin
      x = x + pi_q / 2;
      if (x >= 2 * pi_q) x = x - 2 * pi_q;
    end
    if (x >= pi_q) begin
      x   = x - pi_q;
      neg = 1'b1;
    end
    if (x > pi_q / 2) x = pi_q - x;
    s = x;
    t = x;
    for (int n = 1; n <= 5; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t;
      else s = s + t;
    end
    r = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // q14 product floored back to q14
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  task automatic blank_frame();
    for (int i = 0; i < COLS*ROWS; i++) begin
      glyph_mem[i] = BLANK_GLYPH;
      depth_mem[i] = '0;
    end
  endtask

  // project one surface sample, depth test it and update the frame
  task automatic render_sample(input int unsigned th, input int unsigned ph,
                               output res_t res);
    longint cth, sth, cph, sph, ca, sa, cb, sb, r1, r2, vd, sum;
    longint cx, cy, tx, tz, ty2, tz2, tx3, ty3, z, nx, nz, ny2, nz2, ny3, lum;
    longint den, sx, sy, inv, li;
    int     cidx;
    res = '0;
    cth = wave_q14(th, 1);   sth = wave_q14(th, 0);
    cph = wave_q14(ph, 1);   sph = wave_q14(ph, 0);
    ca  = wave_q14(tilt, 1); sa  = wave_q14(tilt, 0);
    cb  = wave_q14(spin, 1); sb  = wave_q14(spin, 0);
    r1  = major_r;
    r2  = minor_r;
    vd  = view_d;
    sum = (r1 + r2 != 0) ? r1 + r2 : 1;
    cx  = (r1 << 14) + r2 * cph;
    cy  = r2 * sph;
    tx  = qmul(cx, cth);
    tz  = -qmul(cx, sth);
    ty2 = qmul(cy, ca) + qmul(tz, sa);
    tz2 = qmul(tz, ca) - qmul(cy, sa);
    tx3 = qmul(tx, cb) + qmul(ty2, sb);
    ty3 = qmul(ty2, cb) - qmul(tx, sb);
    z   = vd * 1024 + tz2;
    nx  = qmul(cph, cth);
    nz  = -qmul(sth, cph);
    ny2 = qmul(sph, ca) + qmul(nz, sa);
    nz2 = qmul(nz, ca) - qmul(sph, sa);
    ny3 = qmul(ny2, cb) - qmul(nx, sb);
    lum = ny3 - nz2;
    // point behind the viewer
    if (z <= 0) begin
      res.off_screen = 1'b1;
      return;
    end
    den = 128 * sum * z;
    sx  = (COLS * den + 6 * COLS * vd * tx3) / (2 * den);
    sy  = (ROWS * den - 6 * ROWS * vd * ty3) / (2 * den);
    if (sx < 0 || sx >= COLS || sy < 0 || sy >= ROWS) begin
      res.off_screen = 1'b1;
      return;
    end
    res.cell_col = sx[COL_W-1:0];
    res.cell_row = sy[ROW_W-1:0];
    inv  = (longint'(1) << 28) / z;
    if (inv > 65535) inv = 65535;
    cidx = int'(sy * COLS + sx);
    if (inv > longint'(depth_mem[cidx])) begin
      li = (lum < 0) ? 0 : (lum * 8) >>> 14;
      if (li > 11) li = 11;
      depth_mem[cidx] = inv[DEPTH_W-1:0];
      glyph_mem[cidx] = shade[li];
      res.glyph       = shade[li];
      res.drawn       = 1'b1;
    end
  endtask

  task automatic report(input string what, input longint exp_v, input longint got_v);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      blank_frame();
      major_r = RST_MAJOR;
      minor_r = RST_MINOR;
      view_d  = RST_VIEW;
      tilt    = RST_ANGLE;
      spin    = RST_ANGLE;
      pending_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAJOR: major_r = cfg_data[3:0];
          CFG_MINOR: minor_r = cfg_data[3:0];
          CFG_VIEW:  view_d  = cfg_data[7:0];
          CFG_TILT:  tilt    = cfg_data;
          CFG_SPIN:  spin    = cfg_data;
          default: ;
        endcase
      end
      // result transfer, checked against the oldest prediction
      if (out_pop && !out_empty) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with nothing expected, col %0d row %0d glyph %0d",
                   $time, out_cell_col, out_cell_row, out_glyph);
        end else begin
          exp_r = pending_q.pop_front();
          if (out_cell_col !== exp_r.cell_col) report("cell_col", exp_r.cell_col, out_cell_col);
          if (out_cell_row !== exp_r.cell_row) report("cell_row", exp_r.cell_row, out_cell_row);
          if (out_glyph !== exp_r.glyph) report("glyph", exp_r.glyph, out_glyph);
          if (out_drawn !== exp_r.drawn) report("drawn", exp_r.drawn, out_drawn);
          if (out_off_screen !== exp_r.off_screen)
            report("off_screen", exp_r.off_screen, out_off_screen);
          if (exp_r.drawn) drawn_cnt++;
          if (exp_r.off_screen) dropped_cnt++;
        end
      end
      // item transfer
      if (in_push && !in_full) begin
        exp_r = '0;
        case (op_t'(in_func))
          OP_CLEAR: blank_frame();
          OP_PLOT:  render_sample(in_theta_index, in_phi_index, exp_r);
          OP_READ: begin
            exp_r.cell_col = in_read_col;
            exp_r.cell_row = in_read_row;
            exp_r.glyph    = glyph_mem[int'(in_read_row) * COLS + int'(in_read_col)];
          end
          default: ;
        endcase
        pending_q.push_back(exp_r);
      end
    end
    waiting = pending_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the torus point renderer: directed items, then random plots,
// reads, clears and no-ops over eight register settings and four idling patterns
// ----------------------------------------------------------------------------
module tb;
  import tpz_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_push;
  logic                 in_full;
  logic [FUNC_W-1:0]    in_func;
  logic [ANG_W-1:0]     in_theta_index;
  logic [ANG_W-1:0]     in_phi_index;
  logic [COL_W-1:0]     in_read_col;
  logic [ROW_W-1:0]     in_read_row;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [COL_W-1:0]     out_cell_col;
  logic [ROW_W-1:0]     out_cell_row;
  logic [GLYPH_W-1:0]   out_glyph;
  logic                 out_drawn;
  logic                 out_off_screen;

  int errors, waiting, drawn_cnt, dropped_cnt;
  int items_sent;
  int send_idle_pct;   // chance per cycle that the sender holds off
  int pop_stall_pct;   // chance per cycle that the receiver stalls

  torus_point_zbuffer_renderer uut (.*);

  tpz_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_full, .in_func, .in_theta_index, .in_phi_index,
    .in_read_col, .in_read_row,
    .out_empty, .out_pop, .out_cell_col, .out_cell_row, .out_glyph,
    .out_drawn, .out_off_screen,
    .errors, .waiting, .drawn_cnt, .dropped_cnt
  );

  // 12 ns clock
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // receiver side: pop decided at each falling edge
  always @(negedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // one item transfer; gaps come from send_idle_pct, push stays high
  // across back-to-back transfers
  task automatic push_item(input op_t op, input int unsigned th,
                           input int unsigned ph,
                           input int unsigned col,
                           input int unsigned row);
    bit done;
    done = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_func        = op;
    in_theta_index = ANG_W'(th);
    in_phi_index   = ANG_W'(ph);
    in_read_col    = COL_W'(col);
    in_read_row    = ROW_W'(row);
    in_push        = 1'b1;
    while (!done) begin
      @(posedge clk);
      done = !in_full;
      @(negedge clk);
    end
    in_push = 1'b0;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // wait until every predicted result has been popped, then a short pause
  task automatic drain();
    int guard;
    guard = 0;
    while (waiting != 0 && guard < 300000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else if (r < 4) push_item(OP_NOP, $urandom, $urandom, $urandom, $urandom);
    else if (r < 72) push_item(OP_PLOT, $urandom, $urandom, $urandom, $urandom);
    else if (r < 86) push_item(OP_READ, $urandom, $urandom, $urandom, $urandom);
    // reads aimed at the middle of the frame, where the torus lands
    else push_item(OP_READ, $urandom, $urandom, $urandom_range(16, 48),
                   $urandom_range(2, 30));
  endtask

  initial begin
    int unsigned maj, mnr, sum;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MAJOR;
    cfg_data       = '0;
    in_push        = 1'b0;
    in_func        = FUNC_CLEAR;
    in_theta_index = '0;
    in_phi_index   = '0;
    in_read_col    = '0;
    in_read_row    = '0;
    items_sent     = 0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset settings
    push_item(OP_READ, 0, 0, 0, 0);
    push_item(OP_PLOT, 0, 0, 0, 0);
    push_item(OP_PLOT, 511, 511, 0, 0);
    push_item(OP_PLOT, 0, 511, 0, 0);
    push_item(OP_PLOT, 511, 0, 0, 0);
    push_item(OP_PLOT, 128, 256, 0, 0);
    push_item(OP_PLOT, 128, 256, 0, 0);  // same cell again, depth test lost
    push_item(OP_PLOT, 384, 128, 63, 31);
    push_item(OP_READ, 0, 0, 63, 31);
    push_item(OP_READ, 511, 511, 44, 16);
    push_item(OP_READ, 0, 0, 32, 16);
    push_item(OP_NOP, 511, 511, 63, 31);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_READ, 0, 0, 44, 16);
    push_item(OP_PLOT, 0, 0, 0, 0);
    push_item(OP_READ, 0, 0, 44, 16);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin maj = 15; mnr = 15; write_reg(CFG_VIEW, 16);
                 write_reg(CFG_TILT, 511); write_reg(CFG_SPIN, 511); end
        1: begin maj = 0; mnr = 0; write_reg(CFG_VIEW, 255);  // both radii zero
                 write_reg(CFG_TILT, 0); write_reg(CFG_SPIN, 0); end
        2: begin maj = 1; mnr = 0; write_reg(CFG_VIEW, 16);
                 write_reg(CFG_TILT, 128); write_reg(CFG_SPIN, 64); end
        3: begin maj = 2; mnr = 1; write_reg(CFG_VIEW, 80);
                 write_reg(CFG_TILT, 0); write_reg(CFG_SPIN, 0); end
        default: begin
          maj = $urandom_range(1, 6);
          mnr = $urandom_range(0, 4);
          sum = maj + mnr;
          write_reg(CFG_VIEW, $urandom_range(sum * 16 + 8, 255));
          write_reg(CFG_TILT, $urandom_range(0, 511));
          write_reg(CFG_SPIN, $urandom_range(0, 511));
        end
      endcase
      write_reg(CFG_MAJOR, maj);
      write_reg(CFG_MINOR, mnr);
      // idling pattern: none, sender idle, receiver stall, both lightly
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 84; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 84; end
        default: begin send_idle_pct = 7; pop_stall_pct = 7; end
      endcase
      for (int i = 0; i < 75; i++) random_item();
    end

    drain();
    $display("run covered %0d items over eight settings: %0d cells drawn, %0d samples dropped",
             items_sent, drawn_cnt, dropped_cnt);
    if (errors == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, waiting);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", waiting);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* torus_point_zbuffer_renderer.f */
hdl/tpz_pkg.sv
hdl/tpz_front.sv
hdl/tpz_div.sv
hdl/tpz_engine.sv
hdl/torus_point_zbuffer_renderer.sv
tb/tpz_checker.sv
tb/tb.sv
